FILE: design/peak_normalize_real_vector_defines.svh
// ----------------------------------------------------------------------------
// Peak normalise: shared assertion macros
// Immediate-implication and next-cycle forms, clocked on clk_i with reset off.
// ----------------------------------------------------------------------------
`ifndef PEAK_NORMALIZE_REAL_VECTOR_DEFINES_SVH
`define PEAK_NORMALIZE_REAL_VECTOR_DEFINES_SVH

// Same-cycle implication.
`define PNRV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PNRV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pnrv_pkg.sv
// ----------------------------------------------------------------------------
// pnrv_pkg
// Types and constants shared by the peak normaliser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pnrv_pkg;

  localparam int unsigned SampleW       = 16;
  localparam int unsigned ScaleW        = 32;
  localparam int unsigned MaxLenDefault = 64;
  // Divider dividend width: covers 2^(SampleW+15) + peak/2 and mag * 2^(SampleW-1) + peak/2.
  localparam int unsigned NumW  = ((SampleW + 16) > (2 * SampleW)) ? (SampleW + 16)
                                                                    : (2 * SampleW);
  localparam int unsigned StepW = $clog2(NumW + 1);

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } pnrv_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] scaled;
    logic [ScaleW-1:0]         scale;
    logic                      end_of_run;
  } pnrv_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;         // input request accepted
    logic start_scale;  // launch 1/peak division
    logic take_scale;   // capture the scale
    logic rd_en;        // read the next stored sample
    logic start_samp;   // launch sample/peak division
    logic emit;         // load the output register
  } pnrv_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_busy;
    logic out_free;
    logic last_elem;
  } pnrv_stat_t;

endpackage

`default_nettype wire

FILE: design/peak_normalize_real_vector.sv
// ----------------------------------------------------------------------------
// peak_normalize_real_vector
// Buffers a signed vector, then emits it divided by its peak magnitude.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i): one sample per request,
//   Q1.15 by default; the request with .last set closes the vector. Requests
//   are taken back to back while loading. Samples past MaxLen are dropped.
//   After the closing request the input stalls while the block forms
//   scale = 1/peak (Q16.16) on a bit-serial divider.
//   Each stored sample then takes a store read, a SampleW-step division on
//   the shared divider and an emit; the next read waits for that emit.
//   Output channel (out_valid_o / out_stall_i / out_data_o): one request per
//   stored sample, carrying the scaled sample, the scale and end_of_run on
//   the final one. A zero peak passes the samples through with scale 0.
//   The output register holds while out_stall_i is high; the sequencer waits
//   for it, and the next vector may load while the last result is pending.
//   Reset (rst_ni low, asynchronous) empties the vector and clears the peak;
//   store contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_normalize_real_vector
  import pnrv_pkg::*;
#(
  parameter int unsigned MaxLen = MaxLenDefault  // store depth, 2 to 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire pnrv_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output pnrv_out_t      out_data_o
);

  pnrv_cmd_t  cmd;
  pnrv_stat_t stat;

  // Sequencer: owns all phase decisions.
  pnrv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Store, peak, divider and output register.
  pnrv_datapath #(
    .MaxLen (MaxLen)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: design/pnrv_ram.sv
// ----------------------------------------------------------------------------
// pnrv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pnrv_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/pnrv_div.sv
// ----------------------------------------------------------------------------
// pnrv_div
// Restoring divider, one quotient bit per cycle, preloadable partial remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module pnrv_div
  import pnrv_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [SampleW-1:0] rem_i,      // initial partial remainder, < divisor
  input  wire logic [NumW-1:0]    dvd_i,      // dividend bits, MSB first
  input  wire logic [StepW-1:0]   steps_i,    // quotient bits to produce
  input  wire logic [SampleW-1:0] divisor_i,  // held stable while busy
  output logic                    busy_o,
  output logic      [NumW-1:0]    quot_o
);

  logic               busy_q;
  logic [StepW-1:0]   cnt_q;
  logic [SampleW-1:0] rem_q;
  logic [NumW-1:0]    dvd_q;
  logic [NumW-1:0]    quo_q;

  logic [SampleW:0]   shifted;
  logic [SampleW:0]   diff;
  logic               ge;
  logic [SampleW-1:0] rem_d;

  assign shifted = {rem_q, dvd_q[NumW-1]};
  assign ge      = shifted >= {1'b0, divisor_i};
  assign diff    = shifted - {1'b0, divisor_i};
  assign rem_d   = ge ? diff[SampleW-1:0] : shifted[SampleW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      dvd_q <= dvd_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[NumW-2:0], 1'b0};
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

FILE: design/pnrv_datapath.sv
// ----------------------------------------------------------------------------
// pnrv_datapath
// Sample store, peak tracking, divider operand set-up and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "peak_normalize_real_vector_defines.svh"

module pnrv_datapath
  import pnrv_pkg::*;
#(
  parameter int unsigned MaxLen = MaxLenDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pnrv_in_t   in_data_i,
  input  wire pnrv_cmd_t  cmd_i,
  output pnrv_stat_t      stat_o,
  input  wire logic       out_stall_i,
  output logic            out_valid_o,
  output pnrv_out_t       out_data_o
);

  localparam int unsigned CntW  = $clog2(MaxLen + 1);
  localparam int unsigned AddrW = $clog2(MaxLen);
  localparam logic [NumW-1:0] ScaleNum  = NumW'(1) << (SampleW + 15);
  localparam logic [NumW-1:0] ScaleMaxN = NumW'({ScaleW{1'b1}});
  localparam logic [SampleW:0] Half     = (SampleW + 1)'(1) << (SampleW - 1);

  logic [CntW-1:0]    fill_q;
  logic [SampleW-1:0] peak_q;
  logic [AddrW-1:0]   idx_q;
  logic [ScaleW-1:0]  scale_q;
  logic               out_valid_q;
  pnrv_out_t          out_q;

  logic               store_ok;
  logic [SampleW-1:0] in_mag;
  logic [SampleW-1:0] rd_raw;
  logic [SampleW-1:0] rd_mag;
  logic [SampleW-1:0] half_peak;
  logic [NumW-1:0]    scl_n;
  logic [NumW-1:0]    smp_n;
  logic               div_busy;
  logic [NumW-1:0]    quot;
  logic [SampleW-1:0] div_rem;
  logic [NumW-1:0]    div_dvd;
  logic [StepW-1:0]   div_steps;
  logic [SampleW:0]   q_s;
  logic [SampleW:0]   q_neg_lim;
  logic [SampleW:0]   q_neg;
  logic [SampleW-1:0] norm;
  logic               last_elem;
  logic               out_free;

  // Two's complement magnitude; the most negative code maps to 2^(SampleW-1).
  assign in_mag = in_data_i.sample[SampleW-1] ? (~in_data_i.sample + SampleW'(1))
                                              : in_data_i.sample;
  assign rd_mag = rd_raw[SampleW-1] ? (~rd_raw + SampleW'(1)) : rd_raw;

  assign store_ok  = fill_q < CntW'(MaxLen);
  assign half_peak = peak_q >> 1;
  assign scl_n     = ScaleNum + NumW'(half_peak);
  assign smp_n     = (NumW'(rd_mag) << (SampleW - 1)) + NumW'(half_peak);

  pnrv_ram #(
    .Width (SampleW),
    .Depth (MaxLen)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && store_ok),
    .waddr_i (fill_q[AddrW-1:0]),
    .wdata_i (in_data_i.sample),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_raw)
  );

  // Sample quotient is at most 2^(SampleW-1), so SampleW steps suffice once
  // the top half of the dividend is preloaded as the partial remainder.
  always_comb begin
    if (cmd_i.start_samp) begin
      div_rem   = smp_n[2*SampleW-1:SampleW];
      div_dvd   = {smp_n[SampleW-1:0], {(NumW-SampleW){1'b0}}};
      div_steps = StepW'(SampleW);
    end else begin
      div_rem   = '0;
      div_dvd   = scl_n;
      div_steps = StepW'(NumW);
    end
  end

  pnrv_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.start_scale || cmd_i.start_samp),
    .rem_i     (div_rem),
    .dvd_i     (div_dvd),
    .steps_i   (div_steps),
    .divisor_i (peak_q),
    .busy_o    (div_busy),
    .quot_o    (quot)
  );

  // Round-half-away quotient back to signed, saturating +1.0.
  assign q_s       = quot[SampleW:0];
  assign q_neg_lim = (q_s > Half) ? Half : q_s;
  assign q_neg     = ~q_neg_lim + (SampleW + 1)'(1);
  always_comb begin
    if (rd_raw[SampleW-1]) begin
      norm = q_neg[SampleW-1:0];
    end else if (q_s > Half - (SampleW + 1)'(1)) begin
      norm = SampleW'(Half - (SampleW + 1)'(1));
    end else begin
      norm = q_s[SampleW-1:0];
    end
  end

  assign last_elem = (CntW'(idx_q) + CntW'(1)) == fill_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      peak_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && store_ok) begin
        fill_q <= fill_q + CntW'(1);
        if (in_mag > peak_q) begin
          peak_q <= in_mag;
        end
      end
      if (cmd_i.start_scale) begin
        idx_q <= '0;
      end
      if (cmd_i.emit) begin
        idx_q <= idx_q + AddrW'(1);
        if (last_elem) begin
          fill_q <= '0;
          peak_q <= '0;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_scale) begin
      if (peak_q == '0) begin
        scale_q <= '0;
      end else if (quot > ScaleMaxN) begin
        scale_q <= '1;
      end else begin
        scale_q <= ScaleW'(quot);
      end
    end
    if (cmd_i.emit) begin
      out_q.scaled     <= (peak_q == '0) ? rd_raw : norm;
      out_q.scale      <= scale_q;
      out_q.end_of_run <= last_elem;
    end
  end

  assign stat_o.div_busy  = div_busy;
  assign stat_o.out_free  = out_free;
  assign stat_o.last_elem = last_elem;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

  `PNRV_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CntW'(MaxLen), "fill count beyond store depth")
  `PNRV_ASSERT_NOW(a_emit_free, cmd_i.emit, out_free, "output register overwritten")
  `PNRV_ASSERT_NEXT(a_drain_clears, cmd_i.emit && last_elem, (fill_q == '0) && (peak_q == '0),
                    "vector state not cleared after drain")

endmodule

`default_nettype wire

FILE: design/pnrv_ctrl.sv
// ----------------------------------------------------------------------------
// pnrv_ctrl
// Sequencer: load, reciprocal, then per-sample read / divide / emit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "peak_normalize_real_vector_defines.svh"

module pnrv_ctrl
  import pnrv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_last_i,
  output logic            in_stall_o,
  input  wire pnrv_stat_t stat_i,
  output pnrv_cmd_t       cmd_o
);

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_SCL_GO  = 3'd1;
  localparam logic [2:0] S_SCL_DIV = 3'd2;
  localparam logic [2:0] S_RD      = 3'd3;
  localparam logic [2:0] S_SMP_GO  = 3'd4;
  localparam logic [2:0] S_SMP_DIV = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = S_SCL_GO;
        end
      end
      S_SCL_GO: begin
        cmd_o.start_scale = 1'b1;
        state_d           = S_SCL_DIV;
      end
      S_SCL_DIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.take_scale = 1'b1;
          state_d          = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SMP_GO;
      end
      S_SMP_GO: begin
        cmd_o.start_samp = 1'b1;
        state_d          = S_SMP_DIV;
      end
      S_SMP_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = stat_i.last_elem ? S_LOAD : S_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_LOAD;

  `PNRV_ASSERT_NEXT(a_div_launch, state_q == S_SMP_GO, stat_i.div_busy, "divider did not start")
  `PNRV_ASSERT_NOW(a_no_load_in_div, stat_i.div_busy, in_stall_o, "input open during division")
  `PNRV_ASSERT_NEXT(a_drain_end, cmd_o.emit && stat_i.last_elem, state_q == S_LOAD,
                    "no return to load after final result")

endmodule

`default_nettype wire
